[src/fractal_value_noise_3d_core_assert.svh]
// Assertion macros shared by the checker of the fractal value noise core.
`ifndef FRACTAL_VALUE_NOISE_3D_CORE_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_3D_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define FVN3_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define FVN3_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also runs through reset
`define FVN3_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/fvn3_pkg.sv]
// Shared types, constants and the blend schedule of the fractal value noise core.
package fvn3_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int          CFG_IDX_W        = 8;
    localparam logic [7:0]  REG_BASE_FREQ    = 8'd0;
    localparam logic [7:0]  REG_OCTAVE_COUNT = 8'd1;
    localparam logic [7:0]  REG_PERSISTENCE  = 8'd2;
    localparam logic [7:0]  REG_NOISE_SEED   = 8'd3;

    localparam logic [31:0] RST_BASE_FREQ   = 32'd16777216;
    localparam logic [3:0]  RST_OCTAVES     = 4'd4;
    localparam logic [15:0] RST_PERSISTENCE = 16'd32768;
    localparam logic [31:0] RST_SEED        = 32'd0;

    localparam logic [31:0] HASH_MUL_A = 32'd747796405;
    localparam logic [31:0] HASH_ADD_A = 32'd2891336453;
    localparam logic [31:0] HASH_MUL_B = 32'd277803737;
    localparam logic [31:0] SEED_STEP  = 32'd97;

    localparam int HASH_STAGES = 4;
    localparam int QUOT_W      = 18;
    localparam int STACK_STEPS = 15;

    typedef logic [2:0][31:0] corner_t;

    typedef struct packed {
        logic        valid;
        corner_t     corner;
        logic [31:0] word;
    } hash_lane_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_SPLIT,
        ST_HASH,
        ST_STACK,
        ST_ACC,
        ST_AMP,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_MERGE_X,
        OP_MERGE_Y,
        OP_MERGE_Z
    } stack_op_t;

    function automatic stack_op_t stack_op(input logic [3:0] step);
        stack_op_t op;
        unique case (step)
            4'd2, 4'd5, 4'd9, 4'd12: op = OP_MERGE_X;
            4'd6, 4'd13:             op = OP_MERGE_Y;
            4'd14:                   op = OP_MERGE_Z;
            default:                 op = OP_PUSH;
        endcase
        return op;
    endfunction

endpackage

[src/fvn3_hash_cell.sv]
// One link of the lattice hash chain: a two-stage integer mixing round.
module fvn3_hash_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  fvn3_pkg::hash_lane_t lane_i,
    output fvn3_pkg::hash_lane_t lane_o
);

    logic [31:0]       a_reg;
    logic [31:0]       w_reg;
    fvn3_pkg::corner_t corner_a_reg;
    fvn3_pkg::corner_t corner_b_reg;
    logic              valid_a_reg;
    logic              valid_b_reg;
    logic [4:0]        rot_amt;
    logic [31:0]       rot_word;

    assign rot_amt  = {1'b0, a_reg[31:28]} + 5'd4;
    assign rot_word = (a_reg >> rot_amt) ^ a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            valid_a_reg <= lane_i.valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg        <= lane_i.word * fvn3_pkg::HASH_MUL_A + fvn3_pkg::HASH_ADD_A;
        corner_a_reg <= lane_i.corner;
        w_reg        <= rot_word * fvn3_pkg::HASH_MUL_B;
        corner_b_reg <= corner_a_reg;
    end

    assign lane_o.valid  = valid_b_reg;
    assign lane_o.corner = corner_b_reg;
    assign lane_o.word   = (w_reg >> 22) ^ w_reg;

endmodule

[src/fractal_value_noise_3d_core.sv]
// Top level of the fractal value noise core: sequencer, octave datapath and hash chain.
//
// Usage:
//   s_ channel takes one point (pos_x, pos_y, pos_z, signed fixed point) per transfer.
//   m_ channel returns one noise_value (signed Q0.15) per accepted point, in order.
//   cfg_ channel writes base_frequency, octave_count, persistence, noise_seed by
//   index 0..3; other indexes are ignored. Write only while the block is idle.
// Sequence:
//   One point at a time. A point goes through the coordinate products, then per
//   octave through split and smoothstep, the four-cell hash chain for the eight
//   corners, the blend stack and accumulation, then through a restoring divide.
//   Zero frequency or zero octaves go straight to the result.
// Reset and stalls:
//   aresetn (synchronous, active low) restores the register defaults and empties
//   the block. s_tready rises again once the result sits in the output register,
//   so the next point is taken while m_tready holds the previous result back.
module fractal_value_noise_3d_core #(
    parameter int MAX_OCTAVES = fvn3_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = fvn3_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,     // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // noise_value [15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
    localparam int LOG_OC = $clog2(MAX_OCTAVES);
    localparam int NORM_W = 17 + LOG_OC;
    localparam int SUM_W  = 32 + LOG_OC;
    localparam int Q_W    = fvn3_pkg::QUOT_W;

    logic [31:0] base_freq_reg;
    logic [3:0]  oct_cnt_reg;
    logic [15:0] persist_reg;
    logic [31:0] seed_cfg_reg;

    fvn3_pkg::state_t state_reg, state_next;
    logic [4:0]       cnt_reg;
    logic [2:0]       got_reg;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;

    logic [31:0]        pos_line   [3];
    logic signed [63:0] prod_line  [3];
    logic [31:0]        cell_line  [3];
    logic [15:0]        w_line     [3];
    logic [15:0]        c_sr       [8];
    logic [15:0]        stk        [4];
    logic [15:0]        t_reg;
    logic [31:0]        tt_reg;
    logic [OCT_W-1:0]   oct_reg;
    logic [OCT_W-1:0]   n_reg;
    logic [31:0]        seed_reg;
    logic [16:0]        amp_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [NORM_W-1:0]  norm_reg;
    logic [NORM_W-1:0]  rem_reg;
    logic [Q_W-1:0]     low_reg;

    logic               in_xfer;
    logic               take_out;
    logic               issue_valid;
    logic               is_zero;
    logic               last_oct;
    logic [OCT_W-1:0]   oct_lim;
    logic [5:0]         shamt;
    logic signed [63:0] sh_cell;
    logic [63:0]        sh_frac;
    logic [15:0]        frac_v;
    logic [17:0]        coef;
    logic [49:0]        wprod;
    logic [15:0]        w_v;
    fvn3_pkg::stack_op_t op;
    logic [15:0]        u_sel;
    logic signed [16:0] diff;
    logic signed [33:0] bprod;
    logic signed [33:0] bsum;
    logic [15:0]        blend_v;
    logic [32:0]        acc_prod;
    logic [32:0]        amp_prod;
    logic [SUM_W-1:0]   num;
    logic [NORM_W:0]    trial;
    logic               ge;
    logic [15:0]        q_clamp;

    fvn3_pkg::hash_lane_t issue_lane;
    fvn3_pkg::hash_lane_t lane [fvn3_pkg::HASH_STAGES];

    // configuration registers
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_freq_reg <= fvn3_pkg::RST_BASE_FREQ;
            oct_cnt_reg   <= fvn3_pkg::RST_OCTAVES;
            persist_reg   <= fvn3_pkg::RST_PERSISTENCE;
            seed_cfg_reg  <= fvn3_pkg::RST_SEED;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                fvn3_pkg::REG_BASE_FREQ:    base_freq_reg <= cfg_data;
                fvn3_pkg::REG_OCTAVE_COUNT: oct_cnt_reg   <= cfg_data[3:0];
                fvn3_pkg::REG_PERSISTENCE:  persist_reg   <= cfg_data[15:0];
                fvn3_pkg::REG_NOISE_SEED:   seed_cfg_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(oct_cnt_reg) > 32'(MAX_OCTAVES)) begin
            oct_lim = OCT_W'(MAX_OCTAVES);
        end else begin
            oct_lim = OCT_W'(oct_cnt_reg);
        end
    end

    assign is_zero  = (base_freq_reg == 32'd0) || (oct_lim == '0);
    assign last_oct = (OCT_W'(oct_reg + 1'b1) == n_reg);
    assign in_xfer  = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fvn3_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = is_zero ? fvn3_pkg::ST_DONE : fvn3_pkg::ST_PROD;
                end
            end
            fvn3_pkg::ST_PROD: begin
                if (cnt_reg == 5'd2) state_next = fvn3_pkg::ST_SPLIT;
            end
            fvn3_pkg::ST_SPLIT: begin
                if (cnt_reg == 5'd3) state_next = fvn3_pkg::ST_HASH;
            end
            fvn3_pkg::ST_HASH: begin
                if (lane[fvn3_pkg::HASH_STAGES-1].valid && got_reg == 3'd7) begin
                    state_next = fvn3_pkg::ST_STACK;
                end
            end
            fvn3_pkg::ST_STACK: begin
                if (cnt_reg == 5'(fvn3_pkg::STACK_STEPS - 1)) state_next = fvn3_pkg::ST_ACC;
            end
            fvn3_pkg::ST_ACC: state_next = fvn3_pkg::ST_AMP;
            fvn3_pkg::ST_AMP: begin
                state_next = last_oct ? fvn3_pkg::ST_DIV_INIT : fvn3_pkg::ST_SPLIT;
            end
            fvn3_pkg::ST_DIV_INIT: state_next = fvn3_pkg::ST_DIV;
            fvn3_pkg::ST_DIV: begin
                if (cnt_reg == 5'(Q_W - 1)) state_next = fvn3_pkg::ST_DONE;
            end
            fvn3_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = fvn3_pkg::ST_IDLE;
            end
            default: state_next = fvn3_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready    = 1'b0;
        issue_valid = 1'b0;
        take_out    = 1'b0;
        unique case (state_reg)
            fvn3_pkg::ST_IDLE: s_tready = aresetn;
            fvn3_pkg::ST_HASH: issue_valid = (cnt_reg < 5'd8);
            fvn3_pkg::ST_DONE: take_out = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fvn3_pkg::ST_IDLE;
            cnt_reg      <= '0;
            got_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 5'd0 : 5'(cnt_reg + 1'b1);
            if (lane[fvn3_pkg::HASH_STAGES-1].valid) got_reg <= 3'(got_reg + 1'b1);
            if (take_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // coordinate split and smoothstep weight
    assign shamt   = 6'(FRAC_BITS + 24) - 6'(oct_reg);
    assign sh_cell = prod_line[0] >>> shamt;
    assign sh_frac = 64'(prod_line[0]) >> (shamt - 6'd16);
    assign frac_v  = sh_frac[15:0];
    assign coef    = 18'd196608 - {1'b0, t_reg, 1'b0};
    assign wprod   = 50'(tt_reg) * 50'(coef);
    assign w_v     = (wprod[49:32] > 18'd65535) ? 16'hFFFF : wprod[47:32];

    // corner blend
    assign op = fvn3_pkg::stack_op(cnt_reg[3:0]);

    always_comb begin
        unique case (op)
            fvn3_pkg::OP_MERGE_Y: u_sel = w_line[1];
            fvn3_pkg::OP_MERGE_Z: u_sel = w_line[2];
            default:              u_sel = w_line[0];
        endcase
    end

    assign diff    = $signed({1'b0, stk[0]}) - $signed({1'b0, stk[1]});
    assign bprod   = diff * $signed({1'b0, u_sel});
    assign bsum    = $signed({18'd0, stk[1]}) + (bprod >>> 16);
    assign blend_v = bsum[15:0];

    assign acc_prod = 33'(amp_reg) * 33'(stk[0]);
    assign amp_prod = 33'(amp_reg) * 33'(persist_reg);

    // restoring divide
    assign num     = sum_reg + SUM_W'(norm_reg >> 1);
    assign trial   = {rem_reg, low_reg[Q_W-1]};
    assign ge      = (trial >= {1'b0, norm_reg});
    assign q_clamp = (low_reg > Q_W'(65535)) ? 16'hFFFF : low_reg[15:0];

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            fvn3_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    pos_line[0] <= s_tdata[31:0];
                    pos_line[1] <= s_tdata[63:32];
                    pos_line[2] <= s_tdata[95:64];
                    oct_reg     <= '0;
                    n_reg       <= oct_lim;
                    seed_reg    <= seed_cfg_reg;
                    amp_reg     <= 17'd65536;
                    sum_reg     <= '0;
                    norm_reg    <= '0;
                    low_reg     <= Q_W'(32768);
                end
            end
            fvn3_pkg::ST_PROD: begin
                prod_line[0] <= prod_line[1];
                prod_line[1] <= prod_line[2];
                prod_line[2] <= 64'($signed(pos_line[0]) * $signed({1'b0, base_freq_reg}));
                pos_line[0]  <= pos_line[1];
                pos_line[1]  <= pos_line[2];
            end
            fvn3_pkg::ST_SPLIT: begin
                if (cnt_reg < 5'd3) begin
                    prod_line[0] <= prod_line[1];
                    prod_line[1] <= prod_line[2];
                    prod_line[2] <= prod_line[0];
                    cell_line[0] <= cell_line[1];
                    cell_line[1] <= cell_line[2];
                    cell_line[2] <= sh_cell[31:0];
                    t_reg        <= frac_v;
                    tt_reg       <= 32'(frac_v) * 32'(frac_v);
                end
                if (cnt_reg != 5'd0) begin
                    w_line[0] <= w_line[1];
                    w_line[1] <= w_line[2];
                    w_line[2] <= w_v;
                end
            end
            fvn3_pkg::ST_STACK: begin
                if (op == fvn3_pkg::OP_PUSH) begin
                    stk[0] <= c_sr[0];
                    stk[1] <= stk[0];
                    stk[2] <= stk[1];
                    stk[3] <= stk[2];
                end else begin
                    stk[0] <= blend_v;
                    stk[1] <= stk[2];
                    stk[2] <= stk[3];
                end
            end
            fvn3_pkg::ST_ACC: begin
                sum_reg  <= sum_reg + SUM_W'(acc_prod);
                norm_reg <= norm_reg + NORM_W'(amp_reg);
            end
            fvn3_pkg::ST_AMP: begin
                amp_reg  <= amp_prod[32:16];
                oct_reg  <= OCT_W'(oct_reg + 1'b1);
                seed_reg <= seed_reg + fvn3_pkg::SEED_STEP;
            end
            fvn3_pkg::ST_DIV_INIT: begin
                rem_reg <= NORM_W'(num >> Q_W);
                low_reg <= num[Q_W-1:0];
            end
            fvn3_pkg::ST_DIV: begin
                rem_reg <= ge ? NORM_W'(trial - {1'b0, norm_reg}) : trial[NORM_W-1:0];
                low_reg <= {low_reg[Q_W-2:0], ge};
            end
            fvn3_pkg::ST_DONE: begin
                if (take_out) m_tdata_reg <= q_clamp ^ 16'h8000;
            end
            default: ;
        endcase
    end

    // corner values arrive in order; drain them into the blend stack
    always_ff @(posedge aclk) begin
        if (lane[fvn3_pkg::HASH_STAGES-1].valid ||
            (state_reg == fvn3_pkg::ST_STACK && op == fvn3_pkg::OP_PUSH)) begin
            for (int i = 0; i < 7; i++) begin
                c_sr[i] <= c_sr[i+1];
            end
            c_sr[7] <= lane[fvn3_pkg::HASH_STAGES-1].word[31:16];
        end
    end

    // hash chain
    assign issue_lane.valid     = issue_valid;
    assign issue_lane.corner[0] = cell_line[0] + 32'(cnt_reg[0]);
    assign issue_lane.corner[1] = cell_line[1] + 32'(cnt_reg[1]);
    assign issue_lane.corner[2] = cell_line[2] + 32'(cnt_reg[2]);
    assign issue_lane.word      = (cell_line[0] + 32'(cnt_reg[0])) ^ seed_reg;

    for (genvar gi = 0; gi < fvn3_pkg::HASH_STAGES; gi++) begin : g_cell
        fvn3_pkg::hash_lane_t cell_in;
        if (gi == 0) begin : g_head
            assign cell_in = issue_lane;
        end else if (gi < 3) begin : g_coord
            assign cell_in.valid  = lane[gi-1].valid;
            assign cell_in.corner = lane[gi-1].corner;
            assign cell_in.word   = lane[gi-1].corner[gi] ^ lane[gi-1].word;
        end else begin : g_final
            assign cell_in = lane[gi-1];
        end
        fvn3_hash_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .lane_i  (cell_in),
            .lane_o  (lane[gi])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/fvn3_checker.sv]
// Port-level checker for the fractal value noise core, bound to the top level.
`include "fractal_value_noise_3d_core_assert.svh"

module fvn3_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    `FVN3_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `FVN3_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid, "result present after reset")
    `FVN3_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while busy")

endmodule

bind fractal_value_noise_3d_core fvn3_checker u_fvn3_checker (.*);

[dv/tb_fractal_value_noise_3d_core.sv]
// Testbench of the fractal value noise core: random stream stimulus, predictor and checker.
module tb_fractal_value_noise_3d_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;     // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // noise_value [15:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    fractal_value_noise_3d_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [31:0] mdl_freq;
    logic [3:0]  mdl_octaves;
    logic [15:0] mdl_persist;
    logic [31:0] mdl_seed;

    point_t      pending_points[$];
    logic [15:0] expected_noise[$];
    int          mismatches = 0;
    int          results_seen = 0;
    bit          no_gaps = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          hold_cnt = 0;
    bit          hold_done = 1'b0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] pcg_mix(input logic [31:0] v_in);
        logic [31:0] v, w;
        v = v_in * fvn3_pkg::HASH_MUL_A + fvn3_pkg::HASH_ADD_A;
        w = ((v >> (v[31:28] + 32'd4)) ^ v) * fvn3_pkg::HASH_MUL_B;
        return (w >> 22) ^ w;
    endfunction

    function automatic logic [31:0] lattice_value(input logic [31:0] cx, cy, cz, seed);
        logic [31:0] h;
        h = pcg_mix(cx ^ seed);
        h = pcg_mix(cy ^ h);
        h = pcg_mix(cz ^ h);
        return pcg_mix(h) >> 16;
    endfunction

    function automatic logic [31:0] smoothstep_q16(input logic [31:0] t);
        logic [63:0] tt, r;
        tt = 64'(t) * 64'(t);
        r = (tt * 64'(32'd196608 - 2 * t)) >> 32;
        return (r > 64'd65535) ? 32'd65535 : r[31:0];
    endfunction

    function automatic logic [31:0] lerp_q16(input logic [31:0] a, b, u);
        logic [63:0] r;
        r = (64'(a) * 64'(32'd65536 - u) + 64'(b) * 64'(u)) >> 16;
        return r[31:0];
    endfunction

    function automatic logic [31:0] octave_value(input point_t pt, input logic [31:0] freq,
                                                 input int oct, input logic [31:0] seed);
        logic [31:0] pos[3];
        logic [31:0] lat[3], wt[3], n[8];
        longint      prod;
        longint      fl;
        int          s;
        pos[0] = pt.x; pos[1] = pt.y; pos[2] = pt.z;
        s = 40 - oct;
        for (int k = 0; k < 3; k++) begin
            prod = longint'($signed(pos[k])) * longint'({32'd0, freq});
            fl = prod >>> s;
            lat[k] = fl[31:0];
            wt[k] = smoothstep_q16({16'd0, 16'(prod >> (s - 16))});
        end
        for (int k = 0; k < 8; k++)
            n[k] = lattice_value(lat[0] + 32'(k & 1), lat[1] + 32'((k >> 1) & 1),
                                 lat[2] + 32'((k >> 2) & 1), seed);
        return lerp_q16(lerp_q16(lerp_q16(n[0], n[1], wt[0]), lerp_q16(n[2], n[3], wt[0]),
                                 wt[1]),
                        lerp_q16(lerp_q16(n[4], n[5], wt[0]), lerp_q16(n[6], n[7], wt[0]),
                                 wt[1]), wt[2]);
    endfunction

    function automatic logic [15:0] fbm_noise(input point_t pt);
        logic [63:0] amp, sum, norm, r;
        int          n;
        amp = 64'd65536; sum = '0; norm = '0;
        n = (mdl_octaves > fvn3_pkg::MAX_OCTAVES_DEF) ? fvn3_pkg::MAX_OCTAVES_DEF
                                                      : int'(mdl_octaves);
        if (mdl_freq == 0 || n == 0)
            return 16'd0;
        for (int i = 0; i < n; i++) begin
            sum += amp * 64'(octave_value(pt, mdl_freq, i,
                                          mdl_seed + 32'(i) * fvn3_pkg::SEED_STEP));
            norm += amp;
            amp = (amp * 64'(mdl_persist)) >> 16;
        end
        r = (sum + norm / 2) / norm;
        if (r > 64'd65535)
            r = 64'd65535;
        return 16'(r[31:0] - 32'd32768);
    endfunction

    function automatic int pick_gap();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_noise.push_back(fbm_noise(point_t'(s_tdata)));
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                s_tdata <= pending_points.pop_front();
                s_tvalid <= 1'b1;
                in_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && results_seen == 100 && !hold_done) begin
            hold_cnt <= 800;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_noise.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result noise_value=%0d", $signed(m_tdata));
                end else begin
                    logic [15:0] want;
                    want = expected_noise.pop_front();
                    if (want !== m_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("noise_value mismatch: expected %0d actual %0d",
                                     $signed(want), $signed(m_tdata));
                    end
                end
            end
            if (hold_cnt > 0 || (results_seen == 100 && !hold_done)) begin
                m_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    out_gap <= pick_gap();
            end
        end
    end

    task automatic reg_write(input logic [7:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            fvn3_pkg::REG_BASE_FREQ:    mdl_freq = val;
            fvn3_pkg::REG_OCTAVE_COUNT: mdl_octaves = val[3:0];
            fvn3_pkg::REG_PERSISTENCE:  mdl_persist = val[15:0];
            fvn3_pkg::REG_NOISE_SEED:   mdl_seed = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(input logic [31:0] f, input logic [3:0] o, input logic [15:0] p,
                         input logic [31:0] sd);
        reg_write(fvn3_pkg::REG_BASE_FREQ, f);
        reg_write(fvn3_pkg::REG_OCTAVE_COUNT, {28'd0, o});
        reg_write(fvn3_pkg::REG_PERSISTENCE, {16'd0, p});
        reg_write(fvn3_pkg::REG_NOISE_SEED, sd);
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_points.size() > 0 || s_tvalid || expected_noise.size() > 0);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            2: return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
        endcase
    endfunction

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            pending_points.push_back('{z: rand_coord(), y: rand_coord(), x: rand_coord()});
    endtask

    task automatic push_directed();
        logic [31:0] vals[8];
        vals = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0000_FFFF, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0001};
        for (int i = 0; i < 8; i++)
            pending_points.push_back('{z: vals[(i + 2) % 8], y: vals[(i + 1) % 8], x: vals[i]});
    endtask

    initial begin
        mdl_freq = fvn3_pkg::RST_BASE_FREQ;
        mdl_octaves = fvn3_pkg::RST_OCTAVES;
        mdl_persist = fvn3_pkg::RST_PERSISTENCE;
        mdl_seed = fvn3_pkg::RST_SEED;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults, no idling
        no_gaps = 1'b1;
        push_directed();
        drain();
        no_gaps = 1'b0;

        setup(32'h0, 4'd4, 16'h8000, 32'h1234_5678);
        push_directed();
        drain();
        setup(32'h0100_0000, 4'd0, 16'h8000, 32'h0);
        push_random(3);
        drain();
        setup(32'hFFFF_FFFF, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        push_directed();
        drain();
        setup(32'h0000_0001, 4'd8, 16'h0000, 32'hDEAD_BEEF);
        reg_write(8'd7, 32'hFFFF_FFFF);
        reg_write(8'hFF, 32'h0);
        push_random(4);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            logic [3:0] o;
            o = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 15))
                                            : 4'($urandom_range(1, 3));
            setup(($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(1, 8)) << 22,
                  o, 16'($urandom()), $urandom());
            no_gaps = (ph == 3);
            push_random(80);
            drain();
        end

        repeat (400) @(posedge aclk);
        if (mismatches == 0 && expected_noise.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
